// File: rtl/rotation_matrix_to_quaternion_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion unit
// Reset-guarded implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH

// same-cycle implication
`define RMQ_ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define RMQ_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// File: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int ElemW = 16;

  typedef struct packed {
    logic signed [ElemW-1:0] m00;
    logic signed [ElemW-1:0] m01;
    logic signed [ElemW-1:0] m02;
    logic signed [ElemW-1:0] m10;
    logic signed [ElemW-1:0] m11;
    logic signed [ElemW-1:0] m12;
    logic signed [ElemW-1:0] m20;
    logic signed [ElemW-1:0] m21;
    logic signed [ElemW-1:0] m22;
  } matrix_t;

  typedef struct packed {
    logic signed [ElemW-1:0] qx;
    logic signed [ElemW-1:0] qy;
    logic signed [ElemW-1:0] qz;
    logic signed [ElemW-1:0] qw;
    logic                    degenerate;
  } quat_t;

  // branch select: which component is the half root
  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2,
    SEL_W = 2'd3
  } sel_t;

  // differences and sums of two elements fit 17 bits
  localparam int DiffW = ElemW + 1;

endpackage

// File: rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Branch selection, radicand and off-diagonal terms, one register stage.
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int FRAC_BITS = 14,
  parameter int RadW      = FRAC_BITS + 20
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  rmq_pkg::matrix_t                         m,
  output logic [RadW-1:0]                          rad,
  output logic                                     degen,
  output rmq_pkg::sel_t                            sel,
  output logic signed [rmq_pkg::DiffW-1:0]         d0,
  output logic signed [rmq_pkg::DiffW-1:0]         d1,
  output logic signed [rmq_pkg::DiffW-1:0]         d2
);

  // room for one plus three elements, whichever is wider
  localparam int SumW = (rmq_pkg::ElemW > FRAC_BITS ? rmq_pkg::ElemW : FRAC_BITS) + 3;
  localparam int OneW = FRAC_BITS + 2;

  logic signed [SumW-1:0] a00, a11, a22, tr, one, r;
  logic signed [rmq_pkg::DiffW-1:0] e01, e02, e10, e12, e20, e21;
  rmq_pkg::sel_t s;
  logic signed [rmq_pkg::DiffW-1:0] x0, x1, x2;

  always_comb begin
    a00 = SumW'(m.m00);
    a11 = SumW'(m.m11);
    a22 = SumW'(m.m22);
    e01 = rmq_pkg::DiffW'(m.m01);
    e02 = rmq_pkg::DiffW'(m.m02);
    e10 = rmq_pkg::DiffW'(m.m10);
    e12 = rmq_pkg::DiffW'(m.m12);
    e20 = rmq_pkg::DiffW'(m.m20);
    e21 = rmq_pkg::DiffW'(m.m21);
    one = SumW'(signed'({1'b0, {1'b1, {(OneW-2){1'b0}}}}));
    tr  = a00 + a11 + a22;
    if (tr > 0) begin
      s  = rmq_pkg::SEL_W;
      r  = tr + one;
      x0 = e12 - e21;
      x1 = e20 - e02;
      x2 = e01 - e10;
    end else if (a00 > a11 && a00 > a22) begin
      s  = rmq_pkg::SEL_X;
      r  = one + a00 - a11 - a22;
      x0 = e12 - e21;
      x1 = e10 + e01;
      x2 = e20 + e02;
    end else if (a11 > a22) begin
      s  = rmq_pkg::SEL_Y;
      r  = one + a11 - a00 - a22;
      x0 = e20 - e02;
      x1 = e10 + e01;
      x2 = e21 + e12;
    end else begin
      s  = rmq_pkg::SEL_Z;
      r  = one + a22 - a00 - a11;
      x0 = e01 - e10;
      x1 = e20 + e02;
      x2 = e21 + e12;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degen <= (r <= 0);
      rad   <= (r <= 0) ? '0 : RadW'({r[SumW-2:0], {FRAC_BITS{1'b0}}});
      sel   <= s;
      d0    <= x0;
      d1    <= x1;
      d2    <= x2;
    end
  end

endmodule

// File: rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined restoring square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int RadW = 34,
  parameter int RootW = 17
) (
  input  logic               clk,
  input  logic               en,
  input  logic [RadW-1:0]    rad,
  output logic [RootW-1:0]   root
);

  localparam int RemW = RootW + 2;

  logic [2*RootW-1:0] v   [RootW+1];
  logic [RootW-1:0]   q   [RootW+1];
  logic [RemW-1:0]    rm  [RootW+1];

  always_comb begin
    v[0]  = (2*RootW)'(rad);
    q[0]  = '0;
    rm[0] = '0;
  end

  for (genvar i = 0; i < RootW; i++) begin : g_st
    logic [RemW-1:0] tr, tst;
    always_comb begin
      tr  = {rm[i][RemW-3:0], v[i][2*RootW-1 -: 2]};
      tst = tr - {q[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        v[i+1]  <= {v[i][2*RootW-3:0], 2'b00};
        if (!tst[RemW-1]) begin
          rm[i+1] <= tst;
          q[i+1]  <= {q[i][RootW-2:0], 1'b1};
        end else begin
          rm[i+1] <= tr;
          q[i+1]  <= {q[i][RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = q[RootW];

endmodule

// File: rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, |d| * 2^FRAC_BITS / (2 * root), one bit per
// stage, saturated signed 16-bit result.
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int FRAC_BITS = 14,
  parameter int RootW = 17
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [rmq_pkg::DiffW-1:0]  d,
  input  logic [RootW-1:0]                  root,
  output logic signed [rmq_pkg::ElemW-1:0]  q
);

  // quotient bits kept: enough to detect saturation
  localparam int QW   = rmq_pkg::ElemW + 1;
  localparam int NW   = rmq_pkg::DiffW + FRAC_BITS;
  localparam int DW   = RootW + 1;
  localparam int RemW = DW + 1;

  logic [NW-1:0]   num [QW+1];
  logic [RemW-1:0] rm  [QW+1];
  logic [QW-1:0]   qq  [QW+1];
  logic            ovf [QW+1];
  logic            neg [QW+1];
  logic            zr  [QW+1];
  logic            nz  [QW+1];
  logic [DW-1:0]   dv  [QW+1];
  logic [rmq_pkg::DiffW-1:0] mag;
  logic [NW-1:0] nfull;
  logic [NW-QW-1:0] hi;
  logic [RemW-1:0] hr;

  // high numerator bits above the quotient window: quotient too big if
  // they already reach the divisor
  always_comb begin
    mag   = d[rmq_pkg::DiffW-1] ? rmq_pkg::DiffW'(-d) : rmq_pkg::DiffW'(d);
    nfull = {mag, {FRAC_BITS{1'b0}}};
    hi    = nfull[NW-1:QW];
    hr    = RemW'(hi);
    dv[0] = {root, 1'b0};
    num[0] = nfull;
    rm[0]  = (hr >= RemW'(dv[0])) ? '0 : hr;
    ovf[0] = (hr >= RemW'(dv[0]));
    qq[0]  = '0;
    neg[0] = d[rmq_pkg::DiffW-1];
    zr[0]  = (root == '0);
    nz[0]  = (d != '0);
  end

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [RemW-1:0] tr, tst;
    always_comb begin
      tr  = {rm[i][RemW-2:0], num[i][QW-1-i]};
      tst = tr - RemW'(dv[i]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        num[i+1] <= num[i];
        dv[i+1]  <= dv[i];
        ovf[i+1] <= ovf[i];
        neg[i+1] <= neg[i];
        zr[i+1]  <= zr[i];
        nz[i+1]  <= nz[i];
        if (!tst[RemW-1]) begin
          rm[i+1] <= tst;
          qq[i+1] <= {qq[i][QW-2:0], 1'b1};
        end else begin
          rm[i+1] <= tr;
          qq[i+1] <= {qq[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (zr[QW]) begin
      q = !nz[QW] ? '0 : (neg[QW] ? 16'sh8000 : 16'sh7fff);
    end else if (neg[QW]) begin
      q = (ovf[QW] || qq[QW] > QW'(32768)) ? 16'sh8000
          : rmq_pkg::ElemW'(-qq[QW]);
    end else begin
      q = (ovf[QW] || qq[QW] > QW'(32767)) ? 16'sh7fff
          : rmq_pkg::ElemW'(qq[QW]);
    end
  end

endmodule

// File: rtl/rotation_matrix_to_quaternion_unit.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Rotation matrix (Q2.14) to unit quaternion by the trace method.
//
//   channel   signals                      direction
//   in        in_valid in_stall in_data    matrix in
//   out       out_valid out_stall out_data quaternion out
//
// One transaction per cycle while the output does not stall. Stages: front
// stage, one square-root stage per root bit, then one divider stage per
// quotient bit and a final output register. The whole pipe advances
// together; a stall on the output with a full output register stalls it.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_unit_assert.svh"

module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rmq_pkg::matrix_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rmq_pkg::quat_t   out_data
);

  localparam int RadW  = (rmq_pkg::ElemW > FRAC_BITS ? rmq_pkg::ElemW : FRAC_BITS)
                         + FRAC_BITS + 4;
  localparam int RootW = (RadW + 1) / 2;
  localparam int QW    = rmq_pkg::ElemW + 1;
  localparam int Depth = 1 + RootW + QW;

  logic en;
  logic [Depth-1:0] vld;
  logic [RadW-1:0] rad;
  logic degen;
  rmq_pkg::sel_t sel;
  logic signed [rmq_pkg::DiffW-1:0] d0, d1, d2;
  logic [RootW-1:0] root;
  logic signed [rmq_pkg::DiffW-1:0] sd0 [RootW+1];
  logic signed [rmq_pkg::DiffW-1:0] sd1 [RootW+1];
  logic signed [rmq_pkg::DiffW-1:0] sd2 [RootW+1];
  rmq_pkg::sel_t ss [Depth];
  logic sg [Depth];
  logic [rmq_pkg::ElemW-1:0] hh [QW+1];
  logic signed [rmq_pkg::ElemW-1:0] q0, q1, q2;
  logic [RootW-2:0] hr;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[Depth-2:0], in_valid};
      out_valid <= vld[Depth-1];
    end
  end

  rmq_front #(.FRAC_BITS(FRAC_BITS), .RadW(RadW)) u_front (
    .clk, .en, .m(in_data), .rad, .degen, .sel, .d0, .d1, .d2
  );

  rmq_sqrt #(.RadW(RadW), .RootW(RootW)) u_sqrt (
    .clk, .en, .rad, .root
  );

  always_comb begin
    sd0[0] = d0;
    sd1[0] = d1;
    sd2[0] = d2;
    ss[0]  = sel;
    sg[0]  = degen;
  end

  for (genvar i = 0; i < RootW; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (en) begin
        sd0[i+1] <= sd0[i];
        sd1[i+1] <= sd1[i];
        sd2[i+1] <= sd2[i];
      end
    end
  end

  for (genvar i = 0; i < Depth - 1; i++) begin : g_sl
    always_ff @(posedge clk) begin
      if (en) begin
        ss[i+1] <= ss[i];
        sg[i+1] <= sg[i];
      end
    end
  end

  assign hr = root[RootW-1:1];

  always_comb begin
    hh[0] = (RootW - 1 > 15 && hr > (RootW-1)'(32767)) ? 16'h7fff
            : rmq_pkg::ElemW'(hr);
  end

  for (genvar i = 0; i < QW; i++) begin : g_hl
    always_ff @(posedge clk) begin
      if (en) begin
        hh[i+1] <= hh[i];
      end
    end
  end

  rmq_div #(.FRAC_BITS(FRAC_BITS), .RootW(RootW)) u_div0 (
    .clk, .en, .d(sd0[RootW]), .root, .q(q0)
  );
  rmq_div #(.FRAC_BITS(FRAC_BITS), .RootW(RootW)) u_div1 (
    .clk, .en, .d(sd1[RootW]), .root, .q(q1)
  );
  rmq_div #(.FRAC_BITS(FRAC_BITS), .RootW(RootW)) u_div2 (
    .clk, .en, .d(sd2[RootW]), .root, .q(q2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.degenerate <= sg[Depth-1];
      case (ss[Depth-1])
        rmq_pkg::SEL_W: begin
          out_data.qw <= hh[QW];
          out_data.qx <= q0;
          out_data.qy <= q1;
          out_data.qz <= q2;
        end
        rmq_pkg::SEL_X: begin
          out_data.qw <= q0;
          out_data.qx <= hh[QW];
          out_data.qy <= q1;
          out_data.qz <= q2;
        end
        rmq_pkg::SEL_Y: begin
          out_data.qw <= q0;
          out_data.qx <= q1;
          out_data.qy <= hh[QW];
          out_data.qz <= q2;
        end
        default: begin
          out_data.qw <= q0;
          out_data.qx <= q1;
          out_data.qy <= q2;
          out_data.qz <= hh[QW];
        end
      endcase
    end
  end

  `RMQ_ASSERT_IMP(a_stall_only_full, clk, rst, in_stall, out_valid && out_stall, "bad stall")
  `RMQ_ASSERT_NEXT(a_hold, clk, rst, !en, out_valid && $stable(out_data), "held changed")
  `RMQ_ASSERT_NEXT(a_advance, clk, rst, en && vld[Depth-1], out_valid, "transaction lost")

endmodule

// File: verif/rotation_matrix_to_quaternion_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion checker
// Watches both channels, predicts the quaternion of every accepted matrix
// and compares each accepted result in order, as a whole.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_checker #(
  parameter int FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  rmq_pkg::matrix_t in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  rmq_pkg::quat_t   out_data,
  output int               fail_count,
  output int               pending
);

  rmq_pkg::quat_t quat_q[$];

  assign pending = quat_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] div_root(longint d, longint unsigned root);
    longint unsigned mag;
    longint unsigned q;
    if (root == 0) return d > 0 ? 16'sd32767 : (d < 0 ? -16'sd32768 : 16'sd0);
    mag = d < 0 ? longint'(-d) : d;
    q = (mag << FRAC_BITS) / (2 * root);
    if (d < 0) return q > 32768 ? -16'sd32768 : 16'(-longint'(q));
    return q > 32767 ? 16'sd32767 : 16'(q);
  endfunction

  function automatic logic signed [15:0] half_root(longint unsigned root);
    return (root >> 1) > 32767 ? 16'sd32767 : 16'(root >> 1);
  endfunction

  function automatic rmq_pkg::quat_t matrix_to_quat(rmq_pkg::matrix_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad, one;
    longint unsigned root;
    rmq_pkg::sel_t sel;
    rmq_pkg::quat_t q;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    one = longint'(1) << FRAC_BITS;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      sel = rmq_pkg::SEL_W; rad = tr + one;
    end else if (a00 > a11 && a00 > a22) begin
      sel = rmq_pkg::SEL_X; rad = one + a00 - a11 - a22;
    end else if (a11 > a22) begin
      sel = rmq_pkg::SEL_Y; rad = one + a11 - a00 - a22;
    end else begin
      sel = rmq_pkg::SEL_Z; rad = one + a22 - a00 - a11;
    end
    q.degenerate = rad <= 0;
    root = rad <= 0 ? 0 : int_sqrt(longint'(rad) << FRAC_BITS);
    case (sel)
      rmq_pkg::SEL_W: begin
        q.qw = half_root(root);
        q.qx = div_root(a12 - a21, root);
        q.qy = div_root(a20 - a02, root);
        q.qz = div_root(a01 - a10, root);
      end
      rmq_pkg::SEL_X: begin
        q.qw = div_root(a12 - a21, root);
        q.qx = half_root(root);
        q.qy = div_root(a10 + a01, root);
        q.qz = div_root(a20 + a02, root);
      end
      rmq_pkg::SEL_Y: begin
        q.qw = div_root(a20 - a02, root);
        q.qx = div_root(a10 + a01, root);
        q.qy = half_root(root);
        q.qz = div_root(a21 + a12, root);
      end
      default: begin
        q.qw = div_root(a01 - a10, root);
        q.qx = div_root(a20 + a02, root);
        q.qy = div_root(a21 + a12, root);
        q.qz = half_root(root);
      end
    endcase
    return q;
  endfunction

  always @(posedge clk) begin
    rmq_pkg::quat_t exp_q;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) quat_q.push_back(matrix_to_quat(in_data));
      if (out_valid && !out_stall) begin
        if (quat_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected transaction: %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_q = quat_q.pop_front();
          if (out_data !== exp_q) begin
            if (fail_count < 10) $display("mismatch: exp %p got %p", exp_q, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: verif/rotation_matrix_to_quaternion_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion testbench
// Directed corner matrices, then random rotations and noise under several
// idle and stall patterns, with a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_tb;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  rmq_pkg::matrix_t in_data;
  logic             out_valid;
  logic             out_stall;
  rmq_pkg::quat_t   out_data;
  int               fail_count;
  int               pending;
  int               send_idle_pct;
  int               stall_pct;
  int               hold_cycles;
  logic             hold_req;
  logic             hold_done;

  rotation_matrix_to_quaternion_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  rotation_matrix_to_quaternion_unit_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("** rotation_matrix_to_quaternion_unit: FAILED **");
    $finish;
  end

  // long output hold-off once requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == 299) hold_done <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  function automatic logic signed [15:0] rnd_elem(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(32768))) - 16'sd16384;
      default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // a proper rotation from a random unit quaternion, with small noise
  function automatic rmq_pkg::matrix_t rnd_rotation();
    real w, x, y, z, n;
    real e [9];
    rmq_pkg::matrix_t m;
    w = $urandom_range(2000) - 1000.0; x = $urandom_range(2000) - 1000.0;
    y = $urandom_range(2000) - 1000.0; z = $urandom_range(2000) - 1000.0;
    n = $sqrt(w*w + x*x + y*y + z*z) + 1.0;
    w /= n; x /= n; y /= n; z /= n;
    e[0] = 1 - 2*(y*y + z*z); e[1] = 2*(x*y - z*w); e[2] = 2*(x*z + y*w);
    e[3] = 2*(x*y + z*w); e[4] = 1 - 2*(x*x + z*z); e[5] = 2*(y*z - x*w);
    e[6] = 2*(x*z - y*w); e[7] = 2*(y*z + x*w); e[8] = 1 - 2*(x*x + y*y);
    for (int i = 0; i < 9; i++)
      e[i] = e[i] * 16384.0 + $urandom_range(8) - 4.0;
    m = {16'($rtoi(e[0])), 16'($rtoi(e[1])), 16'($rtoi(e[2])),
         16'($rtoi(e[3])), 16'($rtoi(e[4])), 16'($rtoi(e[5])),
         16'($rtoi(e[6])), 16'($rtoi(e[7])), 16'($rtoi(e[8]))};
    return m;
  endfunction

  task automatic send(rmq_pkg::matrix_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= m;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rmq_pkg::matrix_t m;
    int mode;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    send({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
          16'sd0, 16'sd0, 16'sd16384});
    send({16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
          16'sd0, 16'sd0, -16'sd16384});
    send({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
          16'sd0, 16'sd0, -16'sd16384});
    send({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
          16'sd0, 16'sd0, 16'sd16384});
    send({-16'sd16384, 16'sd5, -16'sd7, 16'sd3, -16'sd16384, 16'sd9,
          16'sd1, -16'sd2, -16'sd16384});
    send({16'sd0, 16'sd100, -16'sd100, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0});
    send({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0});
    send({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, -16'sd1});
    send({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh8000, 16'sh7fff, 16'sh8000});
    send({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh7fff, 16'sh8000, 16'sh7fff});
    send({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh8000, 16'sh8000});
    send({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
          16'sh7fff, 16'sh7fff, 16'sh7fff});
    send({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
          16'sh7fff, 16'sh8000, 16'sh7fff});
    send({-16'sd20000, 16'sh7fff, 16'sh8000, 16'sh8000, -16'sd20000, 16'sh7fff,
          16'sh7fff, 16'sh8000, -16'sd20000});
    send({16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd0,
          -16'sd200});

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = phase == 1 ? 56 : (phase == 3 ? 23 : 0);
      stall_pct = phase == 2 ? 56 : (phase == 3 ? 23 : 0);
      if (phase == 2) hold_req <= 1'b1;
      for (int i = 0; i < 330; i++) begin
        mode = $urandom_range(9);
        if (i % 60 == 59) begin
          send_idle_pct = 0;
          send(rnd_rotation());
          send_idle_pct = phase == 1 ? 56 : (phase == 3 ? 23 : 0);
        end else if (mode < 6) begin
          send(rnd_rotation());
        end else begin
          m = {rnd_elem(mode - 6), rnd_elem(mode - 6), rnd_elem(mode - 6),
               rnd_elem(mode - 6), rnd_elem(mode - 6), rnd_elem(mode - 6),
               rnd_elem(mode - 6), rnd_elem(mode - 6), rnd_elem(mode - 6)};
          send(m);
        end
      end
      if (phase == 1) drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("** rotation_matrix_to_quaternion_unit: PASSED **");
    else
      $display("** rotation_matrix_to_quaternion_unit: FAILED **");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion_unit.sv
verif/rotation_matrix_to_quaternion_unit_checker.sv
verif/rotation_matrix_to_quaternion_unit_tb.sv
